FILE: rtl/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

    localparam logic [7:0] START_MARK     = 8'hAA;
    localparam logic [3:0] LEN_MASK       = 4'hF;
    localparam int         FRAME_OVERHEAD = 5;
    localparam int         OUT_PAYLOAD    = 8;
    // type byte, two identifier bytes and the bytes that reach the output
    localparam int         STORE_DEPTH    = OUT_PAYLOAD + 3;

    typedef struct packed {
        logic [15:0]                  can_id;
        logic [3:0]                   payload_len;
        logic [OUT_PAYLOAD-1:0][7:0]  payload;
    } frame_t;

endpackage
`default_nettype wire

FILE: rtl/serial_can_frame_deframer.sv
`default_nettype none
// channel   signals                                                    direction
// input     in_valid, in_ready, rx_byte                                byte request in
// output    out_valid, out_ready, can_id, payload_len, payload_0..7    frame request out
//
// one byte is taken per cycle while in_ready is high; a frame of length n costs
// n + 5 bytes with the marker; its output is valid in the cycle after its closing byte
// in_ready drops only while a finished frame is held and out_ready is low
// reset clears the byte position, so the block waits for a start marker
module serial_can_frame_deframer
    import cfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      can_id,
    output logic [3:0]       payload_len,
    output logic [7:0]       payload_0,
    output logic [7:0]       payload_1,
    output logic [7:0]       payload_2,
    output logic [7:0]       payload_3,
    output logic [7:0]       payload_4,
    output logic [7:0]       payload_5,
    output logic [7:0]       payload_6,
    output logic [7:0]       payload_7
);

    logic   accept;
    logic   done;
    frame_t frame_asm;
    frame_t frame_held;

    assign accept = in_valid && in_ready;

    cfd_assembler #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .done    (done),
        .frame   (frame_asm)
    );

    cfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (done),
        .frame_in  (frame_asm),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .frame_out (frame_held)
    );

    assign can_id      = frame_held.can_id;
    assign payload_len = frame_held.payload_len;
    assign payload_0   = frame_held.payload[0];
    assign payload_1   = frame_held.payload[1];
    assign payload_2   = frame_held.payload[2];
    assign payload_3   = frame_held.payload[3];
    assign payload_4   = frame_held.payload[4];
    assign payload_5   = frame_held.payload[5];
    assign payload_6   = frame_held.payload[6];
    assign payload_7   = frame_held.payload[7];

endmodule
`default_nettype wire

FILE: rtl/cfd_assembler.sv
`default_nettype none
module cfd_assembler
    import cfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    output logic            done,
    output frame_t          frame
);

    localparam int POS_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_last;
    logic [7:0]       store_reg [STORE_DEPTH];
    logic [3:0]       nibble;
    logic [3:0]       len;

    // on the type byte itself the length comes straight from the input
    assign nibble   = (pos_reg == POS_W'(1)) ? (rx_byte[3:0] & LEN_MASK)
                                             : (store_reg[0][3:0] & LEN_MASK);
    assign len      = (nibble > 4'(MAX_PAYLOAD)) ? 4'(MAX_PAYLOAD) : nibble;
    assign pos_inc  = pos_reg + POS_W'(1);
    assign pos_last = POS_W'(len) + POS_W'(FRAME_OVERHEAD);
    assign done     = accept && (pos_reg != '0) && (pos_inc == pos_last);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                pos_next = (rx_byte == START_MARK) ? POS_W'(1) : '0;
            end
            else if (done)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // bytes past the last output payload slot are counted but not kept
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (accept && (pos_reg == POS_W'(i + 1)))
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        frame.can_id      = {store_reg[2], store_reg[1]};
        frame.payload_len = len;
        for (int i = 0; i < OUT_PAYLOAD; i++)
        begin
            frame.payload[i] = (4'(i) < len) ? store_reg[3 + i] : 8'h00;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cfd_out_stage.sv
`default_nettype none
module cfd_out_stage
    import cfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire frame_t frame_in,
    output logic        can_take,
    output logic        out_valid,
    input  wire logic   out_ready,
    output frame_t      frame_out
);

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    // a new request may enter while the held result leaves in the same cycle
    assign can_take = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_in;
        end
    end

    assign out_valid = valid_reg;
    assign frame_out = frame_reg;

endmodule
`default_nettype wire

FILE: rtl/cfd_checker.sv
`default_nettype none
module cfd_checker
#(
    parameter int MAX_PAYLOAD = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] can_id,
    input  wire logic [3:0]  payload_len,
    input  wire logic [7:0]  payload_0,
    input  wire logic [7:0]  payload_1,
    input  wire logic [7:0]  payload_2,
    input  wire logic [7:0]  payload_3,
    input  wire logic [7:0]  payload_4,
    input  wire logic [7:0]  payload_5,
    input  wire logic [7:0]  payload_6,
    input  wire logic [7:0]  payload_7
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(can_id) && $stable(payload_len) &&
            $stable({payload_7, payload_6, payload_5, payload_4,
                     payload_3, payload_2, payload_1, payload_0}))
        else $error("held result dropped or changed before it was taken");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result held");

    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> payload_len <= 4'(MAX_PAYLOAD))
        else $error("payload length above saturation limit");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (payload_len > 4'd0 || payload_0 == 8'h00) &&
            (payload_len > 4'd1 || payload_1 == 8'h00) &&
            (payload_len > 4'd2 || payload_2 == 8'h00) &&
            (payload_len > 4'd3 || payload_3 == 8'h00) &&
            (payload_len > 4'd4 || payload_4 == 8'h00) &&
            (payload_len > 4'd5 || payload_5 == 8'h00) &&
            (payload_len > 4'd6 || payload_6 == 8'h00) &&
            (payload_len > 4'd7 || payload_7 == 8'h00))
        else $error("payload byte past length is not zero");

endmodule

bind serial_can_frame_deframer cfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_cfd_checker (.*);
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
module tb;
    import cfd_pkg::*;

    localparam int MAX_PAYLOAD      = 8;
    localparam int FRAME_DEPTH      = MAX_PAYLOAD + 3;
    localparam int RANDOM_BYTES     = 760;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 16;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] can_id;
    logic [3:0]  payload_len;
    logic [7:0]  payload_0;
    logic [7:0]  payload_1;
    logic [7:0]  payload_2;
    logic [7:0]  payload_3;
    logic [7:0]  payload_4;
    logic [7:0]  payload_5;
    logic [7:0]  payload_6;
    logic [7:0]  payload_7;

    // deframer shadow state
    int unsigned frame_pos = 0;
    logic [7:0]  frame_bytes [FRAME_DEPTH];
    frame_t      pending_frames [$];

    int  bytes_sent = 0;
    int  bytes_used = 0;
    int  frames_seen = 0;
    int  saturated_frames = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  long_hold = 1'b0;

    serial_can_frame_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .can_id      (can_id),
        .payload_len (payload_len),
        .payload_0   (payload_0),
        .payload_1   (payload_1),
        .payload_2   (payload_2),
        .payload_3   (payload_3),
        .payload_4   (payload_4),
        .payload_5   (payload_5),
        .payload_6   (payload_6),
        .payload_7   (payload_7)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, pending_frames.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void deframe_byte(input logic [7:0] b);
        int unsigned len;
        frame_t      f;
        if (frame_pos == 0)
        begin
            // idle: only the start marker opens a frame
            if (b == START_MARK)
            begin
                frame_pos = 1;
                bytes_used++;
            end
            return;
        end
        bytes_used++;
        if (frame_pos - 1 < FRAME_DEPTH)
            frame_bytes[frame_pos - 1] = b;
        frame_pos++;
        len = frame_bytes[0][3:0];
        if (len > MAX_PAYLOAD)
            len = MAX_PAYLOAD;
        if (frame_pos != len + FRAME_OVERHEAD)
            return;
        f.can_id      = {frame_bytes[2], frame_bytes[1]};
        f.payload_len = len[3:0];
        for (int i = 0; i < OUT_PAYLOAD; i++)
            f.payload[i] = (i < len) ? frame_bytes[3 + i] : 8'h00;
        if (frame_bytes[0][3:0] > MAX_PAYLOAD)
            saturated_frames++;
        pending_frames.push_back(f);
        frame_pos = 0;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [15:0] id,
                              input logic [63:0] data, input logic [7:0] closing);
        int n;
        n = (hdr[3:0] > MAX_PAYLOAD) ? MAX_PAYLOAD : hdr[3:0];
        send_byte(START_MARK);
        send_byte(hdr);
        send_byte(id[7:0]);
        send_byte(id[15:8]);
        for (int i = 0; i < n; i++)
            send_byte(data[8*i +: 8]);
        send_byte(closing);
    endtask

    task automatic send_random_frame(input bit full_length);
        logic [7:0]  hdr;
        logic [63:0] data;
        int          slot;
        hdr  = 8'($urandom_range(0, 255));
        if (full_length)
            hdr[3:0] = 4'(MAX_PAYLOAD);
        else if ($urandom_range(0, 4) != 0)
            hdr[3:0] = 4'($urandom_range(0, MAX_PAYLOAD));
        data = {$urandom, $urandom};
        slot = $urandom_range(0, OUT_PAYLOAD - 1);
        // marker value inside the payload is plain data
        if ($urandom_range(0, 3) == 0)
            data[8*slot +: 8] = START_MARK;
        send_frame(hdr, 16'($urandom_range(0, 65535)), data, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_frames();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_frames.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
    endtask

    task automatic test_short_frame();
        send_frame(8'h00, 16'h0000, 64'h0, 8'hFF);
    endtask

    task automatic test_saturated_frame();
        // nibble 15 clips to eight payload bytes, closing byte zero
        send_frame(8'hFF, 16'hFFFF, 64'h01FF_00AA_7F80_AA55, 8'h00);
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        repeat (4) send_random_frame(1'b1);
        wait (!long_hold);
    endtask

    task automatic test_random_stream(input int target);
        int start;
        int kind;
        start = bytes_used;
        while (bytes_used - start < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind == 1)
            begin
                // broken frame: raw bytes; a later frame first sends whatever it takes to finish
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                while (frame_pos != 0)
                    send_byte(8'($urandom_range(0, 255)));
                send_random_frame(1'b0);
            end
        end
    endtask

    task automatic test_drain_pause();
        while (frame_pos != 0)
            send_byte(8'($urandom_range(0, 255)));
        repeat (3) send_random_frame(1'b0);
        wait_for_frames();
        repeat (3) send_random_frame(1'b0);
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin : check_result
        frame_t want;
        frame_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.can_id      = can_id;
            got.payload_len = payload_len;
            got.payload     = {payload_7, payload_6, payload_5, payload_4,
                               payload_3, payload_2, payload_1, payload_0};
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame id %h len %h", can_id, payload_len);
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_seen++;
                if (got.can_id !== want.can_id)
                    note_mismatch("can_id", want.can_id, got.can_id);
                if (got.payload_len !== want.payload_len)
                    note_mismatch("payload_len", 16'(want.payload_len),
                                  16'(got.payload_len));
                for (int i = 0; i < OUT_PAYLOAD; i++)
                    if (got.payload[i] !== want.payload[i])
                        note_mismatch($sformatf("payload_%0d", i),
                                      16'(want.payload[i]), 16'(got.payload[i]));
            end
        end
    end

    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       phase;
        mode      = RX_ALWAYS;
        mode_left = 0;
        phase     = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 128);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:   out_ready <= (phase % 5 < 2);
                endcase
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_noise();
        test_short_frame();
        test_saturated_frame();
        test_backpressure();
        test_random_stream(RANDOM_BYTES);
        test_drain_pause();

        wait_for_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes, %0d framed; checked %0d frames, %0d with clipped length",
                 bytes_sent, bytes_used, frames_seen, saturated_frames);
        $display("covered idle noise, marker as data, long output stall, drain pause");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/cfd_pkg.sv
rtl/cfd_assembler.sv
rtl/cfd_out_stage.sv
rtl/serial_can_frame_deframer.sv
rtl/cfd_checker.sv
tb/tb.sv
